// ===== hw/rtl/lll_orb_pkg.sv =====
package lll_orb_pkg;

   // Pipeline sizing
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TAYLOR_TERMS      = 12;
   localparam int Q_FRAC            = 30;

   // Datapath widths
   localparam int LOG_X_W  = 31;   // normalized radius mantissa, Q1.30
   localparam int FRAC_W   = 16;   // log2 fraction bits
   localparam int TX_W     = 30;   // series argument, Q0.30
   localparam int TERM_W   = 31;   // series term, Q1.30
   localparam int MANT_W   = 32;   // series sum, Q2.30
   localparam int CORDIC_W = 33;   // CORDIC x, y and z

   // Configuration port
   localparam int CSR_W     = 30;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_NORM   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_SCALE = 2'd2;

   localparam logic [5:0]         POWER_RST      = 6'd0;
   localparam logic signed [24:0] LOG_NORM_RST   = -25'sd60223;
   localparam logic [29:0]        NORM_SCALE_RST = 30'd428323897;

   // Fixed-point constants, Q30
   localparam logic [29:0] LN2_Q30    = 30'd744261118;
   localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
   localparam logic [29:0] KINV_Q30   = 30'd652032874;

   localparam logic [29:0] ATAN_Q30 [0:10] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
      30'd1048576
   };

   typedef struct packed {
      logic [15:0] radius;
      logic [15:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] real_part;
      logic signed [31:0] imag_part;
   } rsp_type;

   // Rotation angle of one CORDIC step, Q30
   function automatic logic [29:0] atan_step(input int step);
      logic [29:0] angle;
      if (step <= 10) begin
         angle = ATAN_Q30[4'(step)];
      end else if (step <= 30) begin
         angle = 30'(64'd1 << (30 - step));
      end else begin
         angle = '0;
      end
      return angle;
   endfunction

endpackage

// ===== hw/rtl/lll_orb_log_cell.sv =====
module lll_orb_log_cell #(
   parameter int STEP   = 1,
   parameter int SIDE_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 prev_valid,
   input  logic [lll_orb_pkg::LOG_X_W-1:0]      prev_x,
   input  logic [lll_orb_pkg::FRAC_W-1:0]       prev_frac,
   input  logic [SIDE_W-1:0]                    prev_side,
   output logic                                 valid_ff,
   output logic [lll_orb_pkg::LOG_X_W-1:0]      x_ff,
   output logic [lll_orb_pkg::FRAC_W-1:0]       frac_ff,
   output logic [SIDE_W-1:0]                    side_ff
);

   localparam int XW = lll_orb_pkg::LOG_X_W;
   localparam int FW = lll_orb_pkg::FRAC_W;

   logic [2*XW-1:0] square;
   logic [XW:0]     scaled;
   logic [XW-1:0]   x_in;
   logic [FW-1:0]   frac_in;

   // Square the mantissa; a carry past 2.0 yields one fraction bit
   always_comb begin
      square  = (2*XW)'(prev_x) * (2*XW)'(prev_x);
      scaled  = square[2*XW-1:lll_orb_pkg::Q_FRAC];
      frac_in = prev_frac;
      if (scaled[XW]) begin
         x_in                = scaled[XW:1];
         frac_in[FW - STEP]  = 1'b1;
      end else begin
         x_in = scaled[XW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         frac_ff <= frac_in;
         side_ff <= prev_side;
      end
   end

endmodule

// ===== hw/rtl/lll_orb_taylor_cell.sv =====
module lll_orb_taylor_cell #(
   parameter int K      = 1,
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               prev_valid,
   input  logic [lll_orb_pkg::TX_W-1:0]       prev_x,
   input  logic [lll_orb_pkg::TERM_W-1:0]     prev_term,
   input  logic [lll_orb_pkg::MANT_W-1:0]     prev_sum,
   input  logic [SIDE_W-1:0]                  prev_side,
   output logic                               valid_ff,
   output logic [lll_orb_pkg::TX_W-1:0]       x_ff,
   output logic [lll_orb_pkg::TERM_W-1:0]     term_ff,
   output logic [lll_orb_pkg::MANT_W-1:0]     sum_ff,
   output logic [SIDE_W-1:0]                  side_ff
);

   localparam int XW = lll_orb_pkg::TX_W;
   localparam int TW = lll_orb_pkg::TERM_W;
   localparam int SW = lll_orb_pkg::MANT_W;
   localparam int KW = $clog2(K + 1);
   localparam logic [32:0]   RECIP   = 33'((65'd1 << 32) / K);
   localparam logic [KW-1:0] DIVISOR = KW'(K);

   // Stage a: multiply previous term by the argument
   logic [TW+XW-1:0] prod_a;
   logic             a_valid_ff;
   logic [TW-1:0]    a_v_ff;
   logic [XW-1:0]    a_x_ff;
   logic [SW-1:0]    a_sum_ff;
   logic [SIDE_W-1:0] a_side_ff;

   // Stage b: quotient estimate through the reciprocal
   logic [TW+32:0]   prod_b;
   logic             b_valid_ff;
   logic [TW-1:0]    b_q_ff;
   logic [TW-1:0]    b_v_ff;
   logic [XW-1:0]    b_x_ff;
   logic [SW-1:0]    b_sum_ff;
   logic [SIDE_W-1:0] b_side_ff;

   // Stage c: correct the estimate and accumulate
   logic [TW+KW-1:0] back;
   logic [TW+KW-1:0] rest;
   logic [TW-1:0]    term_in;
   logic [SW-1:0]    sum_in;

   assign prod_a  = (TW+XW)'(prev_term) * (TW+XW)'(prev_x);
   assign prod_b  = (TW+33)'(a_v_ff) * (TW+33)'(RECIP);
   assign back    = (TW+KW)'(b_q_ff) * (TW+KW)'(DIVISOR);
   assign rest    = (TW+KW)'(b_v_ff) - back;
   assign term_in = b_q_ff + TW'(rest >= (TW+KW)'(DIVISOR));
   assign sum_in  = b_sum_ff + SW'(term_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= prev_valid;
         b_valid_ff <= a_valid_ff;
         valid_ff   <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_v_ff    <= prod_a[TW+XW-1:lll_orb_pkg::Q_FRAC];
         a_x_ff    <= prev_x;
         a_sum_ff  <= prev_sum;
         a_side_ff <= prev_side;
         b_q_ff    <= prod_b[TW+31:32];
         b_v_ff    <= a_v_ff;
         b_x_ff    <= a_x_ff;
         b_sum_ff  <= a_sum_ff;
         b_side_ff <= a_side_ff;
         x_ff      <= b_x_ff;
         term_ff   <= term_in;
         sum_ff    <= sum_in;
         side_ff   <= b_side_ff;
      end
   end

endmodule

// ===== hw/rtl/lll_orb_cordic_cell.sv =====
module lll_orb_cordic_cell #(
   parameter int STEP   = 0,
   parameter int SIDE_W = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   prev_valid,
   input  logic signed [lll_orb_pkg::CORDIC_W-1:0] prev_x,
   input  logic signed [lll_orb_pkg::CORDIC_W-1:0] prev_y,
   input  logic signed [lll_orb_pkg::CORDIC_W-1:0] prev_z,
   input  logic [SIDE_W-1:0]                      prev_side,
   output logic                                   valid_ff,
   output logic signed [lll_orb_pkg::CORDIC_W-1:0] x_ff,
   output logic signed [lll_orb_pkg::CORDIC_W-1:0] y_ff,
   output logic signed [lll_orb_pkg::CORDIC_W-1:0] z_ff,
   output logic [SIDE_W-1:0]                      side_ff
);

   localparam int CW = lll_orb_pkg::CORDIC_W;
   localparam logic signed [CW-1:0] ANGLE = $signed(CW'(lll_orb_pkg::atan_step(STEP)));

   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   logic signed [CW-1:0] x_in;
   logic signed [CW-1:0] y_in;
   logic signed [CW-1:0] z_in;

   // Rotate toward zero residual angle
   always_comb begin
      dx = prev_y >>> STEP;
      dy = prev_x >>> STEP;
      if (!prev_z[CW-1]) begin
         x_in = prev_x - dx;
         y_in = prev_y + dy;
         z_in = prev_z - ANGLE;
      end else begin
         x_in = prev_x + dx;
         y_in = prev_y - dy;
         z_in = prev_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= prev_side;
      end
   end

endmodule

// ===== hw/rtl/lll_orbital_evaluator_top.sv =====
// channel  dir  handshake                  payload
// req_     in   req_valid / req_stall      lll_orb_pkg::req_type  (radius, angle)
// rsp_     out  rsp_valid / rsp_stall      lll_orb_pkg::rsp_type  (real_part, imag_part)
// csr_     in   csr_write_enable           csr_index, csr_data
//
// One item per cycle while req_stall is low; most of the depth is in the 16 log2 squaring
// cells, the 12 three-stage series cells and the CORDIC cells.
// Reset clears every valid bit and loads the register defaults; there is no clearing pass.
// A stalled result holds in the output register while the pipeline keeps taking items
// until its last stage is full; only then does req_stall rise.
module lll_orbital_evaluator_top #(
   parameter int CORDIC_STAGES = lll_orb_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lll_orb_pkg::req_type                  req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lll_orb_pkg::rsp_type                  rsp_item,
   input  logic                                  csr_write_enable,
   input  logic [lll_orb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lll_orb_pkg::CSR_W-1:0]         csr_data
);

   localparam int LX = lll_orb_pkg::LOG_X_W;
   localparam int FW = lll_orb_pkg::FRAC_W;
   localparam int TX = lll_orb_pkg::TX_W;
   localparam int TW = lll_orb_pkg::TERM_W;
   localparam int MW = lll_orb_pkg::MANT_W;
   localparam int CW = lll_orb_pkg::CORDIC_W;
   localparam int NT = lll_orb_pkg::TAYLOR_TERMS;

   localparam logic [1:0] QUAD_NONE  = 2'd0;
   localparam logic [1:0] QUAD_LEFT  = 2'd1;
   localparam logic [1:0] QUAD_HALF  = 2'd2;
   localparam logic [1:0] QUAD_RIGHT = 2'd3;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   typedef struct packed {
      logic [3:0]         lead;
      logic               zero;
      logic [1:0]         quad;
      logic signed [13:0] rem;
      logic [22:0]        r2;
   } log_side_type;

   typedef struct packed {
      logic signed [13:0]   n;
      logic                 zero;
      logic [1:0]           quad;
      logic signed [CW-1:0] z;
   } tay_side_type;

   typedef struct packed {
      logic [MW-1:0]      mant;
      logic signed [13:0] n;
      logic               zero;
      logic [1:0]         quad;
   } cd_side_type;

   localparam int LOG_SIDE_W = $bits(log_side_type);
   localparam int TAY_SIDE_W = $bits(tay_side_type);
   localparam int CD_SIDE_W  = $bits(cd_side_type);

   // Configuration registers
   logic [5:0]         power_ff;
   logic signed [24:0] log_norm_ff;
   logic [29:0]        norm_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff      <= lll_orb_pkg::POWER_RST;
         log_norm_ff   <= lll_orb_pkg::LOG_NORM_RST;
         norm_scale_ff <= lll_orb_pkg::NORM_SCALE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lll_orb_pkg::CSR_POWER:      power_ff      <= csr_data[5:0];
            lll_orb_pkg::CSR_LOG_NORM:   log_norm_ff   <= $signed(csr_data[24:0]);
            lll_orb_pkg::CSR_NORM_SCALE: norm_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline control: the whole row moves unless the output and last stage are both held
   logic pipe_advance;
   logic out_free;
   logic rsp_valid_ff;
   lll_orb_pkg::rsp_type rsp_item_ff;
   logic f1_valid_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign pipe_advance = out_free || !f1_valid_ff;
   assign req_stall    = !pipe_advance;

   // Front stage: normalize radius, reduce phase, square radius
   logic [3:0]   lead_in;
   logic [LX-1:0] norm_x_in;
   logic [21:0]  phase_full;
   logic [15:0]  phase_adj;
   logic [31:0]  rad_sq;
   log_side_type s0_side_in;
   logic         s0_valid_ff;
   logic [LX-1:0] s0_x_ff;
   log_side_type s0_side_ff;

   always_comb begin
      lead_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_item.radius[i]) begin
            lead_in = 4'(i);
         end
      end
   end

   assign norm_x_in  = LX'(req_item.radius) << (5'd30 - {1'b0, lead_in});
   assign phase_full = 22'(power_ff) * 22'(req_item.angle);
   assign phase_adj  = phase_full[15:0] + 16'd8192;
   assign rad_sq     = 32'(req_item.radius) * 32'(req_item.radius);

   always_comb begin
      s0_side_in.lead = lead_in;
      s0_side_in.zero = (req_item.radius == '0);
      s0_side_in.quad = phase_adj[15:14];
      s0_side_in.rem  = $signed({~phase_adj[13], phase_adj[12:0]});
      s0_side_in.r2   = rad_sq[31:9];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         s0_x_ff    <= norm_x_in;
         s0_side_ff <= s0_side_in;
      end
   end

   // Log2 chain: one fraction bit per cell
   logic                  lg_valid [0:FW];
   logic [LX-1:0]         lg_x     [0:FW];
   logic [FW-1:0]         lg_frac  [0:FW];
   logic [LOG_SIDE_W-1:0] lg_side  [0:FW];

   assign lg_valid[0] = s0_valid_ff;
   assign lg_x[0]     = s0_x_ff;
   assign lg_frac[0]  = '0;
   assign lg_side[0]  = s0_side_ff;

   for (genvar i = 1; i <= FW; i++) begin : g_log
      lll_orb_log_cell #(
         .STEP   (i),
         .SIDE_W (LOG_SIDE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (pipe_advance),
         .prev_valid (lg_valid[i-1]),
         .prev_x     (lg_x[i-1]),
         .prev_frac  (lg_frac[i-1]),
         .prev_side  (lg_side[i-1]),
         .valid_ff   (lg_valid[i]),
         .x_ff       (lg_x[i]),
         .frac_ff    (lg_frac[i]),
         .side_ff    (lg_side[i])
      );
   end

   // M1: ln r and the residual phase in radians
   log_side_type       ls;
   logic signed [20:0] lg2;
   logic signed [51:0] ln_prod;
   logic signed [49:0] z_prod;
   logic               m1_valid_ff;
   logic signed [20:0] m1_ln_ff;
   logic signed [CW-1:0] m1_z_ff;
   logic               m1_zero_ff;
   logic [1:0]         m1_quad_ff;
   logic [22:0]        m1_r2_ff;

   assign ls      = log_side_type'(lg_side[FW]);
   assign lg2     = $signed({({1'b0, ls.lead} - 5'd12), lg_frac[FW]});
   assign ln_prod = lg2 * $signed({1'b0, lll_orb_pkg::LN2_Q30});
   assign z_prod  = ls.rem * $signed({1'b0, lll_orb_pkg::TWO_PI_Q30});

   // M2: exponent in Q16
   logic signed [27:0] pow_ln;
   logic signed [27:0] e_in;
   logic               m2_valid_ff;
   logic signed [27:0] m2_e_ff;
   logic signed [CW-1:0] m2_z_ff;
   logic               m2_zero_ff;
   logic [1:0]         m2_quad_ff;

   assign pow_ln = $signed({1'b0, power_ff}) * m1_ln_ff;
   assign e_in   = pow_ln - $signed({5'b0, m1_r2_ff}) + {{3{log_norm_ff[24]}}, log_norm_ff};

   // M3: convert to base 2, split integer and fraction
   logic signed [59:0] y_prod;
   logic               m3_valid_ff;
   logic [FW-1:0]      m3_f_ff;
   logic signed [13:0] m3_n_ff;
   logic signed [CW-1:0] m3_z_ff;
   logic               m3_zero_ff;
   logic [1:0]         m3_quad_ff;

   assign y_prod = m2_e_ff * $signed({1'b0, lll_orb_pkg::LOG2E_Q30});

   // M4: series argument f * ln 2
   logic [45:0]        xt_prod;
   logic               m4_valid_ff;
   logic [TX-1:0]      m4_x_ff;
   tay_side_type       m4_side_ff;

   assign xt_prod = 46'(m3_f_ff) * 46'(lll_orb_pkg::LN2_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         m1_valid_ff <= lg_valid[FW];
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         m1_ln_ff        <= ln_prod[50:30];
         m1_z_ff         <= z_prod[CW+15:16];
         m1_zero_ff      <= ls.zero;
         m1_quad_ff      <= ls.quad;
         m1_r2_ff        <= ls.r2;
         m2_e_ff         <= e_in;
         m2_z_ff         <= m1_z_ff;
         m2_zero_ff      <= m1_zero_ff;
         m2_quad_ff      <= m1_quad_ff;
         m3_f_ff         <= y_prod[45:30];
         m3_n_ff         <= y_prod[59:46];
         m3_z_ff         <= m2_z_ff;
         m3_zero_ff      <= m2_zero_ff;
         m3_quad_ff      <= m2_quad_ff;
         m4_x_ff         <= xt_prod[45:16];
         m4_side_ff.n    <= m3_n_ff;
         m4_side_ff.zero <= m3_zero_ff;
         m4_side_ff.quad <= m3_quad_ff;
         m4_side_ff.z    <= m3_z_ff;
      end
   end

   // Series chain for 2^f: one term per cell
   logic                  ty_valid [0:NT];
   logic [TX-1:0]         ty_x     [0:NT];
   logic [TW-1:0]         ty_term  [0:NT];
   logic [MW-1:0]         ty_sum   [0:NT];
   logic [TAY_SIDE_W-1:0] ty_side  [0:NT];

   assign ty_valid[0] = m4_valid_ff;
   assign ty_x[0]     = m4_x_ff;
   assign ty_term[0]  = TW'(1) << lll_orb_pkg::Q_FRAC;
   assign ty_sum[0]   = MW'(1) << lll_orb_pkg::Q_FRAC;
   assign ty_side[0]  = m4_side_ff;

   for (genvar k = 1; k <= NT; k++) begin : g_taylor
      lll_orb_taylor_cell #(
         .K      (k),
         .SIDE_W (TAY_SIDE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (pipe_advance),
         .prev_valid (ty_valid[k-1]),
         .prev_x     (ty_x[k-1]),
         .prev_term  (ty_term[k-1]),
         .prev_sum   (ty_sum[k-1]),
         .prev_side  (ty_side[k-1]),
         .valid_ff   (ty_valid[k]),
         .x_ff       (ty_x[k]),
         .term_ff    (ty_term[k]),
         .sum_ff     (ty_sum[k]),
         .side_ff    (ty_side[k])
      );
   end

   // CORDIC chain
   tay_side_type         ts;
   cd_side_type          cd_side_first;
   logic                 cd_valid [0:CORDIC_STAGES];
   logic signed [CW-1:0] cd_x     [0:CORDIC_STAGES];
   logic signed [CW-1:0] cd_y     [0:CORDIC_STAGES];
   logic signed [CW-1:0] cd_z     [0:CORDIC_STAGES];
   logic [CD_SIDE_W-1:0] cd_side  [0:CORDIC_STAGES];

   assign ts                 = tay_side_type'(ty_side[NT]);
   assign cd_side_first.mant = ty_sum[NT];
   assign cd_side_first.n    = ts.n;
   assign cd_side_first.zero = ts.zero;
   assign cd_side_first.quad = ts.quad;

   assign cd_valid[0] = ty_valid[NT];
   assign cd_x[0]     = $signed({3'b000, lll_orb_pkg::KINV_Q30});
   assign cd_y[0]     = '0;
   assign cd_z[0]     = ts.z;
   assign cd_side[0]  = cd_side_first;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      lll_orb_cordic_cell #(
         .STEP   (i),
         .SIDE_W (CD_SIDE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (pipe_advance),
         .prev_valid (cd_valid[i]),
         .prev_x     (cd_x[i]),
         .prev_y     (cd_y[i]),
         .prev_z     (cd_z[i]),
         .prev_side  (cd_side[i]),
         .valid_ff   (cd_valid[i+1]),
         .x_ff       (cd_x[i+1]),
         .y_ff       (cd_y[i+1]),
         .z_ff       (cd_z[i+1]),
         .side_ff    (cd_side[i+1])
      );
   end

   // F1: quadrant rotation and magnitude product
   cd_side_type          cs;
   logic signed [CW-1:0] rot_re;
   logic signed [CW-1:0] rot_im;
   logic signed [65:0]   f1_re_ff;
   logic signed [65:0]   f1_im_ff;
   logic signed [13:0]   f1_n_ff;
   logic                 f1_zero_ff;

   assign cs = cd_side_type'(cd_side[CORDIC_STAGES]);

   always_comb begin
      unique case (cs.quad)
         QUAD_NONE: begin
            rot_re = cd_x[CORDIC_STAGES];
            rot_im = cd_y[CORDIC_STAGES];
         end
         QUAD_LEFT: begin
            rot_re = -cd_y[CORDIC_STAGES];
            rot_im = cd_x[CORDIC_STAGES];
         end
         QUAD_HALF: begin
            rot_re = -cd_x[CORDIC_STAGES];
            rot_im = -cd_y[CORDIC_STAGES];
         end
         QUAD_RIGHT: begin
            rot_re = cd_y[CORDIC_STAGES];
            rot_im = -cd_x[CORDIC_STAGES];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         f1_valid_ff <= cd_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         f1_re_ff   <= $signed({1'b0, cs.mant}) * rot_re;
         f1_im_ff   <= $signed({1'b0, cs.mant}) * rot_im;
         f1_n_ff    <= cs.n;
         f1_zero_ff <= cs.zero;
      end
   end

   // Scale by 2^(n-30) with floor and saturate to 32 bits
   function automatic logic signed [31:0] scale_part(input logic signed [65:0] prod,
                                                    input logic signed [13:0] n);
      logic signed [65:0] shifted;
      logic [5:0]         amount;
      logic signed [31:0] result;
      shifted = '0;
      amount  = '0;
      if (n > 14'sd30) begin
         if (prod == '0) begin
            result = '0;
         end else if (prod[65]) begin
            result = SAT_LO[31:0];
         end else begin
            result = SAT_HI[31:0];
         end
      end else begin
         if (n < -14'sd32) begin
            amount = 6'd62;
         end else begin
            amount = 6'(14'sd30 - n);
         end
         shifted = prod >>> amount;
         if (shifted > SAT_HI) begin
            result = SAT_HI[31:0];
         end else if (shifted < SAT_LO) begin
            result = SAT_LO[31:0];
         end else begin
            result = shifted[31:0];
         end
      end
      return result;
   endfunction

   // Output register
   lll_orb_pkg::rsp_type rsp_item_in;

   always_comb begin
      if (f1_zero_ff) begin
         rsp_item_in.real_part = (power_ff == '0) ? $signed({2'b00, norm_scale_ff}) : '0;
         rsp_item_in.imag_part = '0;
      end else begin
         rsp_item_in.real_part = scale_part(f1_re_ff, f1_n_ff);
         rsp_item_in.imag_part = scale_part(f1_im_ff, f1_n_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Checks
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && f1_valid_ff) |-> req_stall)
      else $error("input taken while output and last stage are both held");

   assert property (@(posedge clock) disable iff (reset)
      (out_free && f1_valid_ff && f1_zero_ff) |=> (rsp_item_ff.imag_part == '0))
      else $error("zero radius item with nonzero imaginary part");

   assert property (@(posedge clock) disable iff (reset)
      cd_valid[CORDIC_STAGES] |-> (cs.mant >= (MW'(1) << lll_orb_pkg::Q_FRAC)))
      else $error("series mantissa below one");

endmodule

// ===== test/tb_lll_orbital_evaluator_top.sv =====
module tb_lll_orbital_evaluator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_IDX_W = lll_orb_pkg::CSR_IDX_W;
   localparam int CSR_W     = lll_orb_pkg::CSR_W;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int NUM_STAGES   = lll_orb_pkg::CORDIC_STAGES_DEF;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 1000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lll_orb_pkg::req_type req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lll_orb_pkg::rsp_type rsp_item;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   // Register copies for prediction
   logic [5:0]         cur_power      = lll_orb_pkg::POWER_RST;
   logic signed [24:0] cur_log_norm   = lll_orb_pkg::LOG_NORM_RST;
   logic [29:0]        cur_norm_scale = lll_orb_pkg::NORM_SCALE_RST;

   lll_orb_pkg::rsp_type orbital_queue[$];
   int      mismatch_count = 0;
   int      burst_left = 0;
   int      cycle_count = 0;
   int      stall_mode = 0;
   int      stall_len = 0;

   lll_orbital_evaluator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Scale one CORDIC part by the mantissa and 2^(n-30), then saturate
   function automatic logic signed [31:0] scale_orbital(longint mant, longint c, longint n);
      longint prod;
      longint s;
      longint v;
      prod = mant * c;
      if (n > 30) begin
         if (prod == 0) return 32'sd0;
         return (prod > 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      end
      s = 30 - n;
      if (s > 62) s = 62;
      v = prod >>> s;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return 32'(v);
   endfunction

   // Predict the orbital value for one point under the current registers
   function automatic lll_orb_pkg::rsp_type orbital_value(lll_orb_pkg::req_type it);
      lll_orb_pkg::rsp_type r;
      logic [63:0]  x;
      longint       frac, lg2, lnr, lnorm, e, y, n, mant, cx, cy, z, dx, dy, t, ang;
      longint unsigned f, tx, term, sum, phase, q;
      int           p;
      r = '0;
      if (it.radius == 16'd0) begin
         r.real_part = (cur_power == 6'd0) ? 32'(cur_norm_scale) : 32'sd0;
         return r;
      end
      // log2 by normalization and repeated squaring
      p = 0;
      for (int i = 0; i < 16; i++) if (it.radius[i]) p = i;
      x = 64'(it.radius) << (30 - p);
      frac = 0;
      for (int i = 1; i <= 16; i++) begin
         x = (x * x) >> 30;
         if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            frac = frac | (64'sd1 << (16 - i));
         end
      end
      lg2 = (longint'(p) - 12) * 65536 + frac;
      lnr = (lg2 * longint'(lll_orb_pkg::LN2_Q30)) >>> 30;
      lnorm = longint'(cur_log_norm);
      e = longint'(cur_power) * lnr
          - ((longint'(it.radius) * longint'(it.radius)) >>> 9) + lnorm;
      y = (e * longint'(lll_orb_pkg::LOG2E_Q30)) >>> 30;
      f = longint'(y) & 64'hFFFF;
      n = y >>> 16;
      // 2^f by Taylor series of e^x
      tx = (f * longint'(lll_orb_pkg::LN2_Q30)) >> 16;
      term = 64'd1 << 30;
      sum = term;
      for (int k = 1; k <= lll_orb_pkg::TAYLOR_TERMS; k++) begin
         term = ((term * tx) >> 30) / k;
         sum = sum + term;
      end
      mant = longint'(sum);
      // phase, quadrant and residual angle
      phase = (longint'(cur_power) * longint'(it.angle)) & 64'hFFFF;
      q = ((phase + 8192) >> 14) & 3;
      z = longint'((phase + 8192) & 16383) - 8192;
      z = (z * longint'(lll_orb_pkg::TWO_PI_Q30)) >>> 16;
      cx = longint'(lll_orb_pkg::KINV_Q30);
      cy = 0;
      for (int i = 0; i < NUM_STAGES; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (i <= 10) ang = longint'(lll_orb_pkg::ATAN_Q30[i]);
         else if (i <= 30) ang = 64'sd1 << (30 - i);
         else ang = 0;
         if (z >= 0) begin
            cx = cx - dx; cy = cy + dy; z = z - ang;
         end else begin
            cx = cx + dx; cy = cy - dy; z = z + ang;
         end
      end
      case (q)
         1: begin t = cx; cx = -cy; cy = t; end
         2: begin cx = -cx; cy = -cy; end
         3: begin t = cx; cx = cy; cy = -t; end
         default: ;
      endcase
      r.real_part = scale_orbital(mant, cx, n);
      r.imag_part = scale_orbital(mant, cy, n);
      return r;
   endfunction

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_lll_orbital_evaluator_top: errors");
         $finish;
      end
   end

   // Receiver stall pattern: switch modes every stretch
   always @(posedge clock) begin
      if (stall_len == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_len = $urandom_range(10, 300);
      end
      stall_len = stall_len - 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      lll_orb_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (orbital_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result re=%0d im=%0d",
                        rsp_item.real_part, rsp_item.imag_part);
         end else begin
            want = orbital_queue.pop_front();
            if (rsp_item.real_part !== want.real_part
                || rsp_item.imag_part !== want.imag_part) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                           want.real_part, want.imag_part,
                           rsp_item.real_part, rsp_item.imag_part);
            end
         end
      end
   end

   // Send one item, inserting random gaps between bursts
   task automatic send_point(input logic [15:0] radius, input logic [15:0] angle);
      lll_orb_pkg::req_type it;
      it.radius = radius;
      it.angle = angle;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      orbital_queue.push_back(orbital_value(it));
      burst_left--;
   endtask

   // Drop valid and wait until every predicted result has arrived
   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      while (orbital_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; caller ends the sequence by clearing csr_write_enable
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         lll_orb_pkg::CSR_POWER:      cur_power = data[5:0];
         lll_orb_pkg::CSR_LOG_NORM:   cur_log_norm = data[24:0];
         lll_orb_pkg::CSR_NORM_SCALE: cur_norm_scale = data[29:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [5:0] pw, input logic signed [24:0] ln,
                           input logic [29:0] ns);
      // upper bits set on power and log norm to exercise masking
      write_reg(lll_orb_pkg::CSR_POWER, {24'hFFFFFF, pw});
      write_reg(lll_orb_pkg::CSR_LOG_NORM, {5'h1F, ln});
      write_reg(lll_orb_pkg::CSR_NORM_SCALE, ns);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults;
      send_point(16'd0, 16'd0);
      send_point(16'd4096, 16'd1234);
      send_point(16'd65535, 16'd65535);
      drain();
   endtask

   task automatic test_directed;
      // zero radius with nonzero power, unused index write, extreme angles
      set_regs(6'd1, -25'sd60223, 30'h3FFFFFFF);
      write_reg(CSR_UNUSED, 30'h3FFFFFFF);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      send_point(16'd0, 16'd5);
      send_point(16'd1, 16'd0);
      send_point(16'd4096, 16'd8191);
      send_point(16'd4096, 16'd8192);
      send_point(16'd4096, 16'd16384);
      send_point(16'd4096, 16'd32768);
      send_point(16'd4096, 16'd49152);
      send_point(16'd8192, 16'd65535);
      drain();
      // very large magnitude saturates
      set_regs(6'd63, 25'sd0, 30'd0);
      send_point(16'd0, 16'd0);
      send_point(16'd40000, 16'd100);
      send_point(16'd65535, 16'd30000);
      send_point(16'd20000, 16'd777);
      drain();
      // very small magnitude
      set_regs(6'd0, -25'sd16777216, 30'h3FFFFFFF);
      send_point(16'd0, 16'd0);
      send_point(16'd1, 16'd40000);
      send_point(16'd65535, 16'd24576);
      send_point(16'd2048, 16'd60000);
      drain();
   endtask

   task automatic test_random;
      logic [15:0] rad;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_regs(6'd0, 25'sd0, 30'd0);
            1: set_regs(6'd63, -25'sd16777216, 30'h3FFFFFFF);
            2: set_regs(6'd1, -25'sd60223, 30'd428323897);
            default: set_regs(6'($urandom_range(0, 63)),
                              -25'sd1 * 25'($urandom_range(0, 16777216)),
                              30'($urandom));
         endcase
         for (int k = 0; k < 85; k++) begin
            case ($urandom_range(0, 9))
               0: rad = 16'd0;
               1, 2, 3: rad = 16'($urandom_range(1, 8192));
               default: rad = 16'($urandom);
            endcase
            send_point(rad, 16'($urandom));
         end
         drain();
      end
   endtask

   task automatic test_pressure;
      // fill the pipe, hold off until empty, then refill
      set_regs(6'd5, -25'sd60223, 30'd428323897);
      repeat (3) begin
         repeat (100) send_point(16'($urandom), 16'($urandom));
         req_valid <= 1'b0;
         burst_left = 0;
         while (orbital_queue.size() != 0) @(posedge clock);
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random();
      test_pressure();
      if (mismatch_count == 0 && orbital_queue.size() == 0) begin
         $display("tb_lll_orbital_evaluator_top: clean");
      end else begin
         $display("tb_lll_orbital_evaluator_top: errors");
      end
      $finish;
   end

endmodule
